// File: sv/caf_chunk_header_parser_defines.svh
// assertion macros of the parser, used by the caf_ctrl module
`ifndef CAF_CHUNK_HEADER_PARSER_DEFINES_SVH
`define CAF_CHUNK_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, checked on every edge outside reset
`define CAF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("caf parser check failed");

// next-cycle implication
`define CAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("caf parser check failed");

`endif

// File: sv/caf_pkg.sv
// shared types and constants of the caf chunk header parser
package caf_pkg;

    localparam logic [1:0] PH_MAGIC  = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [31:0] KIND_DESC  = 32'h64657363;
    localparam logic [31:0] KIND_DATA  = 32'h64617461;
    localparam logic [31:0] KIND_PAKT  = 32'h70616B74;
    localparam logic [31:0] CODEC_AAC  = 32'h61616320;
    localparam logic [31:0] CODEC_LPCM = 32'h6C70636D;
    localparam logic [63:0] RATE_LOW   = 64'h40BF400000000000;
    localparam logic [63:0] RATE_HIGH  = 64'h4107700000000000;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_MAGIC    = 4'd1;
    localparam logic [3:0] ST_NEG_LEN  = 4'd2;
    localparam logic [3:0] ST_PAST_END = 4'd3;
    localparam logic [3:0] ST_DESC     = 4'd4;
    localparam logic [3:0] ST_RATE     = 4'd5;
    localparam logic [3:0] ST_DATA     = 4'd6;
    localparam logic [3:0] ST_PAKT     = 4'd7;
    localparam logic [3:0] ST_NEG_CNT  = 4'd8;
    localparam logic [3:0] ST_MISSING  = 4'd9;
    localparam logic [3:0] ST_CODEC    = 4'd10;

    localparam logic [3:0] ID_STATUS = 4'd15;

    typedef struct packed {
        logic       take;
        logic       clr;
        logic       ld_byte;
        logic       ld_fin;
        logic       ld_field;
        logic [3:0] idx;
        logic       fin;
        logic       div_start;
        logic       div_frame;
        logic       div_wr;
    } cmd_t;

    typedef struct packed {
        logic [3:0] code;
        logic       desc_div;
        logic [3:0] fin_code;
        logic       fin_div;
    } stat_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] i);
        logic [7:0] b;
        unique case (i)
            3'd0: b = 8'h63;
            3'd1: b = 8'h61;
            3'd2: b = 8'h66;
            3'd3: b = 8'h66;
            3'd5: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/caf_div.sv
// restoring 64-bit divider, one quotient bit per cycle
module caf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial[64] ? {rem_reg[62:0], quo_reg[63]} : trial[63:0];
            quo_next = {quo_reg[62:0], ~trial[64]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: sv/caf_dpath.sv
// parse state, field store and result registers of the caf parser
module caf_dpath
    import caf_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [7:0]  file_byte,
    input  logic [63:0] div_q,
    output logic [63:0] div_a,
    output logic [63:0] div_b,
    output stat_t       st,
    output logic [3:0]  field_id,
    output logic [63:0] field_value,
    output logic [3:0]  status,
    output logic        last
);

    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [1:0]  phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] kind_reg, kind_next;
    logic [63:0] left_reg, left_next;
    logic [5:0]  pos_reg, pos_next;
    logic        rte_reg, rte_next;
    logic        dseen_reg, dseen_next;
    logic        aseen_reg, aseen_next;
    logic [63:0] fs_reg [15];
    logic [63:0] fs_next [15];

    logic [63:0] sh;
    logic [5:0]  pos_inc;
    logic        done_go;
    logic [5:0]  n;
    logic [3:0]  code;
    logic        desc_div;
    logic [3:0]  fin_code;
    logic        fin_div;
    logic [63:0] f9_fin;
    logic        aseen_fin;
    logic [3:0]  cap_idx;

    logic [3:0]  id_reg;
    logic [63:0] val_reg;
    logic [3:0]  stat_reg;
    logic        last_reg;

    assign sh      = {shift_reg[55:0], file_byte};
    assign pos_inc = (pos_reg < 6'd63) ? pos_reg + 6'd1 : pos_reg;
    assign cap_idx = pos_reg[5:2] - 4'd1;

    // end-of-file checks on the registered state
    always_comb
    begin
        fin_code  = ST_OK;
        fin_div   = 1'b0;
        f9_fin    = fs_reg[9];
        aseen_fin = aseen_reg;
        if (phase_reg == PH_MAGIC)
            fin_code = ST_MAGIC;
        else if (phase_reg == PH_BODY)
        begin
            if (!rte_reg)
                fin_code = ST_PAST_END;
            else
            begin
                f9_fin = left_reg - 64'd4;
                if (aseen_reg || pos_reg < 6'd4)
                    fin_code = ST_DATA;
                aseen_fin = 1'b1;
            end
        end
        if (fin_code == ST_OK)
        begin
            if (!dseen_reg || !aseen_fin)
                fin_code = ST_MISSING;
            else if (fs_reg[1] != 64'(CODEC_AAC) && fs_reg[1] != 64'(CODEC_LPCM))
                fin_code = ST_CODEC;
            else
                fin_div = (fs_reg[1] == 64'(CODEC_LPCM)) && (fs_reg[12] == '0)
                          && (fs_reg[7] != '0);
        end
    end

    assign div_a = cmd.div_frame ? f9_fin : fs_reg[3];
    assign div_b = cmd.div_frame ? fs_reg[7] : fs_reg[4];

    always_comb
    begin
        off_next   = off_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        rte_next   = rte_reg;
        dseen_next = dseen_reg;
        aseen_next = aseen_reg;
        for (int i = 0; i < 15; i++)
            fs_next[i] = fs_reg[i];
        done_go  = 1'b0;
        n        = '0;
        code     = ST_OK;
        desc_div = 1'b0;

        if (cmd.take)
        begin
            off_next = off_reg + OFFSET_BITS'(1);
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (file_byte != magic_byte(off_reg[2:0]))
                        code = ST_MAGIC;
                    else if (off_reg[2:0] == 3'd7)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end
                end
                PH_HEADER:
                begin
                    shift_next = sh;
                    if (pos_reg == 6'd3)
                        kind_next = sh[31:0];
                    if (pos_reg < 6'd11)
                        pos_next = pos_reg + 6'd1;
                    else
                    begin
                        pos_next   = '0;
                        shift_next = '0;
                        if (kind_reg == KIND_DATA)
                            fs_next[8] = 64'(off_reg + OFFSET_BITS'(5));
                        if (sh[63])
                        begin
                            // all-ones size: data runs to the end of the file
                            if (kind_reg == KIND_DATA && (&sh))
                            begin
                                rte_next   = 1'b1;
                                left_next  = '0;
                                phase_next = PH_BODY;
                            end
                            else
                                code = ST_NEG_LEN;
                        end
                        else
                        begin
                            if (kind_reg == KIND_DATA)
                                fs_next[9] = sh - 64'd4;
                            if (sh == '0)
                                done_go = 1'b1;
                            else
                            begin
                                left_next  = sh;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    shift_next = sh;
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        if (kind_reg == KIND_DESC && pos_reg < 6'd32)
                        begin
                            if (pos_reg == 6'd7)
                                fs_next[0] = sh;
                            else if (pos_reg >= 6'd11)
                                fs_next[cap_idx] = {32'd0, sh[31:0]};
                        end
                        else if (kind_reg == KIND_PAKT && pos_reg < 6'd24)
                        begin
                            if (pos_reg == 6'd7)
                                fs_next[11] = sh;
                            else if (pos_reg == 6'd15)
                                fs_next[12] = sh;
                            else if (pos_reg == 6'd19)
                                fs_next[13] = {32'd0, sh[31:0]};
                            else if (pos_reg == 6'd23)
                                fs_next[14] = {32'd0, sh[31:0]};
                        end
                        else if (kind_reg == KIND_DATA && pos_reg == 6'd3)
                            fs_next[10] = {32'd0, sh[31:0]};
                    end
                    pos_next = pos_inc;
                    if (rte_reg)
                        left_next = left_reg + 64'd1;
                    else
                    begin
                        left_next = left_reg - 64'd1;
                        if (left_reg == 64'd1)
                        begin
                            done_go = 1'b1;
                            n       = pos_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // chunk complete: judge it
            if (done_go)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                rte_next   = 1'b0;
                if (kind_reg == KIND_DESC)
                begin
                    if (dseen_reg || n != 6'd32)
                        code = ST_DESC;
                    else
                    begin
                        dseen_next = 1'b1;
                        desc_div   = 1'b1;
                        if (fs_reg[0] < RATE_LOW || fs_reg[0] > RATE_HIGH
                            || fs_reg[5] < 64'd1 || fs_reg[5] > 64'd2)
                            code = ST_RATE;
                    end
                end
                else if (kind_reg == KIND_DATA)
                begin
                    if (aseen_reg || n < 6'd4)
                        code = ST_DATA;
                    else
                        aseen_next = 1'b1;
                end
                else if (kind_reg == KIND_PAKT)
                begin
                    if (n < 6'd24)
                        code = ST_PAKT;
                    else if (fs_reg[11][63] || fs_reg[12][63])
                        code = ST_NEG_CNT;
                end
            end
        end

        if (cmd.fin)
            fs_next[9] = f9_fin;

        if (cmd.div_wr)
        begin
            if (cmd.div_frame)
                fs_next[12] = div_q;
            else
                fs_next[7] = (fs_reg[4] == '0) ? '0 : div_q;
        end

        if (cmd.clr)
        begin
            off_next   = '0;
            phase_next = PH_MAGIC;
            shift_next = '0;
            kind_next  = '0;
            left_next  = '0;
            pos_next   = '0;
            rte_next   = 1'b0;
            dseen_next = 1'b0;
            aseen_next = 1'b0;
            for (int i = 0; i < 15; i++)
                fs_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            phase_reg <= PH_MAGIC;
            shift_reg <= '0;
            kind_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            rte_reg   <= 1'b0;
            dseen_reg <= 1'b0;
            aseen_reg <= 1'b0;
            for (int i = 0; i < 15; i++)
                fs_reg[i] <= '0;
        end
        else
        begin
            off_reg   <= off_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            rte_reg   <= rte_next;
            dseen_reg <= dseen_next;
            aseen_reg <= aseen_next;
            for (int i = 0; i < 15; i++)
                fs_reg[i] <= fs_next[i];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_byte || cmd.ld_fin)
        begin
            id_reg   <= ID_STATUS;
            val_reg  <= cmd.ld_byte ? 64'(code) : 64'(fin_code);
            stat_reg <= cmd.ld_byte ? code : fin_code;
            last_reg <= 1'b1;
        end
        else if (cmd.ld_field)
        begin
            id_reg   <= cmd.idx;
            stat_reg <= ST_OK;
            if (cmd.idx == ID_STATUS)
            begin
                val_reg  <= '0;
                last_reg <= 1'b1;
            end
            else
            begin
                val_reg  <= fs_reg[cmd.idx];
                last_reg <= 1'b0;
            end
        end
    end

    assign st.code     = code;
    assign st.desc_div = desc_div;
    assign st.fin_code = fin_code;
    assign st.fin_div  = fin_div;

    assign field_id    = id_reg;
    assign field_value = val_reg;
    assign status      = stat_reg;
    assign last        = last_reg;

endmodule

// File: sv/caf_ctrl.sv
// sequencer of the caf parser: byte intake, divisions, result emission
`include "caf_chunk_header_parser_defines.svh"

module caf_ctrl
    import caf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  end_of_file,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    input  logic  div_done,
    output cmd_t  cmd
);

    localparam logic [2:0] S_ACCEPT    = 3'd0;
    localparam logic [2:0] S_DIV_DESC  = 3'd1;
    localparam logic [2:0] S_FINISH    = 3'd2;
    localparam logic [2:0] S_DIV_FRAME = 3'd3;
    localparam logic [2:0] S_EMIT      = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       faulted_reg, faulted_next;
    logic       eofp_reg, eofp_next;
    logic [3:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic       acc;
    logic       slot_free;
    logic       load;

    assign in_ready  = (state_reg == S_ACCEPT) && !ov_reg;
    assign acc       = in_valid && in_ready;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        faulted_next = faulted_reg;
        eofp_next    = eofp_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.idx      = idx_reg;
        cmd.div_frame = (state_reg == S_FINISH) || (state_reg == S_DIV_FRAME);

        unique case (state_reg)
            S_ACCEPT:
            begin
                if (acc)
                begin
                    if (faulted_reg)
                    begin
                        // bytes after a fault are dropped until the end mark
                        if (end_of_file)
                        begin
                            cmd.clr      = 1'b1;
                            faulted_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.take = 1'b1;
                        if (st.code != ST_OK)
                        begin
                            cmd.ld_byte = 1'b1;
                            if (end_of_file)
                                cmd.clr = 1'b1;
                            else
                                faulted_next = 1'b1;
                        end
                        else if (st.desc_div)
                        begin
                            cmd.div_start = 1'b1;
                            eofp_next     = end_of_file;
                            state_next    = S_DIV_DESC;
                        end
                        else if (end_of_file)
                            state_next = S_FINISH;
                    end
                end
            end
            S_DIV_DESC:
            begin
                if (div_done)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = eofp_reg ? S_FINISH : S_ACCEPT;
                end
            end
            S_FINISH:
            begin
                cmd.fin = 1'b1;
                if (st.fin_code != ST_OK)
                begin
                    cmd.ld_fin = 1'b1;
                    cmd.clr    = 1'b1;
                    state_next = S_ACCEPT;
                end
                else if (st.fin_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_FRAME;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_DIV_FRAME:
            begin
                if (div_done)
                begin
                    cmd.div_wr = 1'b1;
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.ld_field = 1'b1;
                    idx_next     = idx_reg + 4'd1;
                    if (idx_reg == ID_STATUS)
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    assign load    = cmd.ld_byte || cmd.ld_fin || cmd.ld_field;
    assign ov_next = load ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACCEPT;
            faulted_reg <= 1'b0;
            eofp_reg    <= 1'b0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            faulted_reg <= faulted_next;
            eofp_reg    <= eofp_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    `CAF_ASSERT_IMPL(a_load_slot, load, !ov_reg || out_ready)
    `CAF_ASSERT_NEXT(a_clr_unfault, cmd.clr, !faulted_reg)
    `CAF_ASSERT_NEXT(a_emit_end, state_reg == S_EMIT && cmd.ld_field && idx_reg == ID_STATUS,
        state_reg == S_ACCEPT)

endmodule

// File: sv/caf_chunk_header_parser.sv
// caf chunk header parser top level
// Input channel in_valid/in_ready carries one file byte per item with
// end_of_file on the final byte. Output channel out_valid/out_ready carries
// one result per item: field_id, field_value, status, last.
// in_ready drops while a result waits in the output register, so a byte
// that causes a result blocks intake until that result is taken.
// Completing a desc chunk starts the bit-serial 64-bit divider for the
// frame byte count: intake pauses until the divide is done. At the end
// mark the finish state runs the final checks, an lpcm frame count adds
// another divide, and the 15 field results plus a status follow, one per
// cycle when the receiver is ready. A fault gives one status result with
// last set; later bytes are swallowed until the end mark, after which the
// block is in its reset state again. A stalled receiver simply holds the
// result register and the emission sequence. Reset (rst_n low) returns to
// magic checking with all captured fields zero.
module caf_chunk_header_parser
    import caf_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_id,
    output logic [63:0] field_value,
    output logic [3:0]  status,
    output logic        last
);

    cmd_t        cmd;
    stat_t       st;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] div_a;
    logic [63:0] div_b;

    caf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_file (end_of_file),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .st          (st),
        .div_done    (div_done),
        .cmd         (cmd)
    );

    caf_dpath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .file_byte   (file_byte),
        .div_q       (div_q),
        .div_a       (div_a),
        .div_b       (div_b),
        .st          (st),
        .field_id    (field_id),
        .field_value (field_value),
        .status      (status),
        .last        (last)
    );

    caf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

endmodule

// File: bench/testbench.sv
// testbench for the caf chunk header parser: byte-stream stimulus checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import caf_pkg::*;

    localparam int OFFSET_BITS = 32;
    localparam logic [63:0] OFFSET_MASK = 64'hFFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TARGET_ITEMS = 270;
    localparam logic [3:0] STAT_DONTCARE = 4'd15;

    typedef struct packed {
        logic [3:0]  id;
        logic [63:0] value;
        logic [3:0]  stat;
        logic        fin;
    } field_result_t;

    typedef enum logic [3:0] {
        DF_SHORT,
        DF_BAD_MAGIC,
        DF_MAGIC_ONLY,
        DF_NEG_SIZE,
        DF_PAST_END,
        DF_DESC_SHORT,
        DF_DATA_SHORT,
        DF_PAKT_SHORT,
        DF_GOOD_AAC
    } dir_file_t;

    typedef struct packed {
        dir_file_t   shape;
        logic [3:0]  typed_status;
    } stim_row_t;

    // directed files with the status read off by inspection
    localparam stim_row_t DIRECTED_ROWS [9] = '{
        '{DF_SHORT,      ST_MAGIC},
        '{DF_BAD_MAGIC,  ST_MAGIC},
        '{DF_MAGIC_ONLY, ST_MISSING},
        '{DF_NEG_SIZE,   ST_NEG_LEN},
        '{DF_PAST_END,   ST_PAST_END},
        '{DF_DESC_SHORT, ST_DESC},
        '{DF_DATA_SHORT, ST_DATA},
        '{DF_PAKT_SHORT, ST_PAKT},
        '{DF_GOOD_AAC,   ST_OK}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  file_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic [3:0]  status;
    logic        last;

    caf_chunk_header_parser #(.OFFSET_BITS(OFFSET_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .file_byte(file_byte), .end_of_file(end_of_file),
        .out_valid(out_valid), .out_ready(out_ready),
        .field_id(field_id), .field_value(field_value),
        .status(status), .last(last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // parser state of the predictor
    logic [63:0] p_offset;
    logic [1:0]  p_phase;
    logic [63:0] p_shift;
    logic [31:0] p_kind;
    logic [63:0] p_left;
    int unsigned p_pos;
    logic        p_to_end;
    logic        p_desc_seen;
    logic        p_data_seen;
    logic        p_faulted;
    logic [63:0] p_fields [15];

    field_result_t expected_results[$];
    logic [3:0]    typed_status_q[$];
    int            error_count;
    int            idle_sender_pct;
    int            stall_pct;
    int            quiet_cycles;
    logic [7:0]    file_buf[$];

    function automatic logic [7:0] magic_at(logic [2:0] i);
        logic [7:0] m [8];
        m = '{8'h63, 8'h61, 8'h66, 8'h66, 8'h00, 8'h01, 8'h00, 8'h00};
        return m[i];
    endfunction

    function automatic void put_byte(logic [7:0] b);
        file_buf = {file_buf, b};
    endfunction

    function automatic void put_expected(field_result_t r);
        expected_results = {expected_results, r};
    endfunction

    task automatic parser_clear();
        p_offset = '0;
        p_phase = PH_MAGIC;
        p_shift = '0;
        p_kind = '0;
        p_left = '0;
        p_pos = 0;
        p_to_end = 1'b0;
        p_desc_seen = 1'b0;
        p_data_seen = 1'b0;
        p_faulted = 1'b0;
        for (int i = 0; i < 15; i++)
            p_fields[i] = '0;
    endtask

    function automatic void capture_field(int unsigned pos);
        if ((pos & 3) != 3)
            return;
        if (p_kind == KIND_DESC && pos < 32) begin
            if (pos == 7)
                p_fields[0] = p_shift;
            else if (pos >= 11)
                p_fields[(pos - 11) / 4 + 1] = {32'd0, p_shift[31:0]};
        end
        else if (p_kind == KIND_PAKT && pos < 24) begin
            if (pos == 7)
                p_fields[11] = p_shift;
            else if (pos == 15)
                p_fields[12] = p_shift;
            else if (pos == 19)
                p_fields[13] = {32'd0, p_shift[31:0]};
            else if (pos == 23)
                p_fields[14] = {32'd0, p_shift[31:0]};
        end
        else if (p_kind == KIND_DATA && pos == 3) begin
            p_fields[10] = {32'd0, p_shift[31:0]};
        end
    endfunction

    function automatic logic [3:0] close_chunk();
        int unsigned n;
        n = p_pos;
        p_phase = PH_HEADER;
        p_pos = 0;
        p_to_end = 1'b0;
        if (p_kind == KIND_DESC) begin
            if (p_desc_seen || n != 32)
                return ST_DESC;
            p_desc_seen = 1'b1;
            p_fields[7] = (p_fields[4] != 0) ? p_fields[3] / p_fields[4] : 64'd0;
            if (p_fields[0] < RATE_LOW || p_fields[0] > RATE_HIGH ||
                p_fields[5] < 64'd1 || p_fields[5] > 64'd2)
                return ST_RATE;
        end
        else if (p_kind == KIND_DATA) begin
            if (p_data_seen || n < 4)
                return ST_DATA;
            p_data_seen = 1'b1;
        end
        else if (p_kind == KIND_PAKT) begin
            if (n < 24)
                return ST_PAKT;
            if (p_fields[11][63] || p_fields[12][63])
                return ST_NEG_CNT;
        end
        return ST_OK;
    endfunction

    function automatic logic [3:0] parse_byte(logic [7:0] b);
        logic [63:0] size;
        if (p_phase == PH_MAGIC) begin
            if (p_offset >= 64'd8 || b != magic_at(p_offset[2:0]))
                return ST_MAGIC;
            if (p_offset == 64'd7) begin
                p_phase = PH_HEADER;
                p_pos = 0;
            end
            return ST_OK;
        end
        p_shift = {p_shift[55:0], b};
        if (p_phase == PH_HEADER) begin
            if (p_pos == 3)
                p_kind = p_shift[31:0];
            if (p_pos < 11) begin
                p_pos++;
                return ST_OK;
            end
            size = p_shift;
            p_pos = 0;
            p_shift = '0;
            if (p_kind == KIND_DATA)
                p_fields[8] = (p_offset + 64'd5) & OFFSET_MASK;
            if (size[63]) begin
                if (p_kind == KIND_DATA && size == '1) begin
                    p_to_end = 1'b1;
                    p_left = '0;
                    p_phase = PH_BODY;
                    return ST_OK;
                end
                return ST_NEG_LEN;
            end
            if (p_kind == KIND_DATA)
                p_fields[9] = size - 64'd4;
            if (size == '0)
                return close_chunk();
            p_left = size;
            p_phase = PH_BODY;
            return ST_OK;
        end
        capture_field(p_pos);
        if (p_pos < 63)
            p_pos++;
        if (p_to_end) begin
            p_left++;
            return ST_OK;
        end
        p_left--;
        if (p_left == '0)
            return close_chunk();
        return ST_OK;
    endfunction

    function automatic logic [3:0] end_checks();
        logic [3:0] code;
        if (p_phase == PH_MAGIC)
            return ST_MAGIC;
        if (p_phase == PH_BODY) begin
            if (!p_to_end)
                return ST_PAST_END;
            p_fields[9] = p_left - 64'd4;
            code = close_chunk();
            if (code != ST_OK)
                return code;
        end
        if (!p_desc_seen || !p_data_seen)
            return ST_MISSING;
        if (p_fields[1] != {32'd0, CODEC_AAC} && p_fields[1] != {32'd0, CODEC_LPCM})
            return ST_CODEC;
        if (p_fields[1] == {32'd0, CODEC_LPCM} && p_fields[12] == '0 && p_fields[7] != '0)
            p_fields[12] = p_fields[9] / p_fields[7];
        return ST_OK;
    endfunction

    function automatic void push_status(logic [3:0] code);
        field_result_t r;
        r.id = ID_STATUS;
        r.value = {60'd0, code};
        r.stat = code;
        r.fin = 1'b1;
        put_expected(r);
    endfunction

    // expected results of one accepted byte
    task automatic predict_byte(logic [7:0] b, logic eof);
        logic [3:0] code;
        field_result_t r;
        if (!p_faulted) begin
            code = parse_byte(b);
            if (code != ST_OK) begin
                p_faulted = 1'b1;
                push_status(code);
            end
        end
        p_offset = (p_offset + 64'd1) & OFFSET_MASK;
        if (eof) begin
            if (!p_faulted) begin
                code = end_checks();
                if (code != ST_OK)
                    push_status(code);
                else begin
                    for (int i = 0; i < 15; i++) begin
                        r.id = 4'(i);
                        r.value = p_fields[i];
                        r.stat = ST_OK;
                        r.fin = 1'b0;
                        put_expected(r);
                    end
                    push_status(ST_OK);
                end
            end
            parser_clear();
        end
    endtask

    // drive one byte; called just after a falling edge, returns at a falling edge
    task automatic send_byte(logic [7:0] b, logic eof);
        while ($urandom_range(99, 0) < idle_sender_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        file_byte <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, eof);
        @(negedge clk);
    endtask

    function automatic void add_bytes_be(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(v[i*8 +: 8]);
    endfunction

    function automatic void add_magic();
        for (int i = 0; i < 8; i++)
            put_byte(magic_at(3'(i)));
    endfunction

    function automatic void add_header(logic [31:0] kind, logic [63:0] size);
        add_bytes_be({32'd0, kind}, 4);
        add_bytes_be(size, 8);
    endfunction

    function automatic void add_desc(logic [63:0] rate, logic [31:0] codec,
                                     logic [31:0] pkt_bytes, logic [31:0] pkt_frames,
                                     logic [31:0] chans);
        add_header(KIND_DESC, 64'd32);
        add_bytes_be(rate, 8);
        add_bytes_be({32'd0, codec}, 4);
        add_bytes_be(64'($urandom), 4);
        add_bytes_be({32'd0, pkt_bytes}, 4);
        add_bytes_be({32'd0, pkt_frames}, 4);
        add_bytes_be({32'd0, chans}, 4);
        add_bytes_be(64'($urandom), 4);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_kind();
        case ($urandom_range(4, 0))
            0: return KIND_DESC;
            1: return KIND_DATA;
            2: return KIND_PAKT;
            3: return 32'h66726565;
            default: return $urandom;
        endcase
    endfunction

    function automatic void build_directed_file(dir_file_t shape);
        file_buf.delete();
        case (shape)
            DF_SHORT:
                put_byte(8'hFF);
            DF_BAD_MAGIC: begin
                // wrong magic byte, then ignored bytes to the end mark
                add_magic();
                file_buf[5] = 8'h02;
                put_byte(8'h00);
            end
            DF_MAGIC_ONLY:
                add_magic();
            DF_NEG_SIZE: begin
                add_magic();
                add_header(KIND_PAKT, '1);
            end
            DF_PAST_END: begin
                add_magic();
                add_header(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
                put_byte(8'h00);
            end
            DF_DESC_SHORT: begin
                add_magic();
                add_header(KIND_DESC, 64'd0);
            end
            DF_DATA_SHORT: begin
                add_magic();
                add_header(KIND_DATA, 64'd3);
                add_bytes_be(64'hFF_FFFF, 3);
            end
            DF_PAKT_SHORT: begin
                add_magic();
                add_header(KIND_PAKT, 64'd1);
                put_byte(8'h00);
            end
            default: begin
                // good aac file with a trailing partial header
                add_magic();
                add_desc(RATE_HIGH, CODEC_AAC, 32'd0, 32'd0, 32'd1);
                add_header(KIND_DATA, 64'd4);
                add_bytes_be(64'h8000_0001, 4);
                add_bytes_be(64'd0, 3);
            end
        endcase
    endfunction

    // builds one random file, mostly well formed
    task automatic build_random_file();
        logic [63:0] rate;
        logic [31:0] codec;
        int data_len;
        int n;
        file_buf.delete();
        if ($urandom_range(19, 0) == 0) begin
            n = int'($urandom_range(10, 1));
            for (int i = 0; i < n; i++)
                put_byte(8'($urandom));
            return;
        end
        add_magic();
        if ($urandom_range(9, 0) == 0)
            file_buf[$urandom_range(7, 0)] = 8'($urandom);
        case ($urandom_range(3, 0))
            0: rate = RATE_LOW;
            1: rate = RATE_HIGH;
            2: rate = RATE_LOW + 64'($urandom_range(3, 0)) - 64'd1;
            default: rate = RATE_LOW + {12'd0, 32'($urandom_range(32'h0048_3000, 0)), 20'd0};
        endcase
        codec = ($urandom_range(4, 0) == 0) ? $urandom
              : ($urandom_range(1, 0) != 0 ? CODEC_LPCM : CODEC_AAC);
        if ($urandom_range(5, 0) != 0)
            add_desc(rate, codec,
                     $urandom_range(1, 0) != 0 ? $urandom : $urandom_range(8, 0),
                     $urandom_range(3, 0) == 0 ? 32'd0 : $urandom_range(4, 1),
                     $urandom_range(7, 0) == 0 ? $urandom_range(3, 0)
                                               : $urandom_range(2, 1));
        if ($urandom_range(2, 0) == 0) begin
            add_header(KIND_PAKT, 64'd24 + 64'($urandom_range(3, 0))
                                  - 64'($urandom_range(5, 0) == 0));
            add_bytes_be($urandom_range(3, 0) == 0 ? rand64() : rand64() >> 40, 8);
            add_bytes_be($urandom_range(1, 0) != 0 ? 64'd0
                                                    : rand64() >> $urandom_range(63, 20), 8);
            add_bytes_be(64'($urandom), 4);
            add_bytes_be(64'($urandom), 4);
            n = int'($urandom_range(3, 0));
            for (int i = 0; i < n; i++)
                put_byte(8'($urandom));
        end
        if ($urandom_range(3, 0) == 0) begin
            n = int'($urandom_range(6, 0));
            add_header(rand_kind() == KIND_DESC ? 32'h66726565 : 32'h696e666f, 64'(n));
            for (int i = 0; i < n; i++)
                put_byte(8'($urandom));
        end
        data_len = int'($urandom_range(12, 0));
        if ($urandom_range(9, 0) == 0)
            add_header(KIND_DATA, {1'b1, 63'(rand64())});
        else if ($urandom_range(2, 0) == 0)
            add_header(KIND_DATA, '1);
        else
            add_header(KIND_DATA, 64'(data_len) + 64'($urandom_range(7, 0) == 0));
        for (int i = 0; i < data_len; i++)
            put_byte(8'($urandom));
        n = ($urandom_range(3, 0) == 0) ? int'($urandom_range(11, 1)) : 0;
        for (int i = 0; i < n; i++)
            put_byte(8'($urandom));
    endtask

    // output side: random stall and compare
    always @(negedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge clk) begin
        field_result_t e;
        logic [3:0] typed;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result id %0d value %h status %0d last %b",
                         $time, field_id, field_value, status, last);
                error_count++;
            end
            else begin
                e = expected_results.pop_front();
                if (field_id !== e.id || field_value !== e.value ||
                    status !== e.stat || last !== e.fin) begin
                    $display("%0t: expected id %0d value %h status %0d last %b, got %0d %h %0d %b",
                             $time, e.id, e.value, e.stat, e.fin,
                             field_id, field_value, status, last);
                    error_count++;
                end
                if (e.fin && typed_status_q.size() != 0) begin
                    typed = typed_status_q.pop_front();
                    if (typed != STAT_DONTCARE && status !== typed) begin
                        $display("%0t: expected status %0d, got %0d", $time, typed, status);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no accepted item on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_file_typed(logic [3:0] typed);
        typed_status_q = {typed_status_q, typed};
        foreach (file_buf[i])
            send_byte(file_buf[i], i == file_buf.size() - 1);
    endtask

    task automatic set_phase(int k);
        case (k % 4)
            0: begin idle_sender_pct = 0;  stall_pct = 0;  end
            1: begin idle_sender_pct = 56; stall_pct = 0;  end
            2: begin idle_sender_pct = 0;  stall_pct = 56; end
            default: begin idle_sender_pct = 16; stall_pct = 16; end
        endcase
    endtask

    initial begin
        int sent;
        int file_count;
        rst_n = 1'b0;
        in_valid = 1'b0;
        file_byte = '0;
        end_of_file = 1'b0;
        idle_sender_pct = 0;
        stall_pct = 0;
        sent = 0;
        file_count = 0;
        parser_clear();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[k]) begin
            set_phase(file_count);
            file_count++;
            build_directed_file(DIRECTED_ROWS[k].shape);
            send_file_typed(DIRECTED_ROWS[k].typed_status);
            sent += file_buf.size();
        end

        // random files
        while (sent < TARGET_ITEMS) begin
            set_phase(file_count);
            file_count++;
            build_random_file();
            send_file_typed(STAT_DONTCARE);
            sent += file_buf.size();
        end
        in_valid <= 1'b0;
        set_phase(0);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/caf_pkg.sv
sv/caf_div.sv
sv/caf_dpath.sv
sv/caf_ctrl.sv
sv/caf_chunk_header_parser.sv
bench/testbench.sv
